### rtl/ifs_pkg.sv
package ifs_pkg;

   // Default sizes
   localparam int DEF_MAX_MAPS   = 8;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_FRAC_BITS  = 16;

   // Fixed field widths and constants
   localparam int COEFS_PER_MAP = 6;
   localparam int COORD_W       = 40;
   localparam int SPLIT_W       = 20;
   localparam int ACC_W         = 82;
   localparam int WEIGHT_W      = 31;
   localparam int BIN_W         = 32;
   localparam int CSR_DATA_W    = 9;
   localparam int DIVERGE_LIMIT = 100000;

   // Sequencer counts
   localparam int CNT_W    = 5;
   localparam int TERM_W   = 4;
   localparam int N_TERMS  = 10;
   localparam int MAC_LAST = 11;
   localparam int DIV_LAST = WEIGHT_W - 1;

   typedef enum logic [2:0] {
      OP_LOAD_COEF   = 3'd0,
      OP_LOAD_WEIGHT = 3'd1,
      OP_SET_POINT   = 3'd2,
      OP_STEP        = 3'd3,
      OP_READ_BIN    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_MAP_COUNT    = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              capture;
      logic              exec_load;
      logic              div_init;
      logic              div_step;
      logic              rem_fin;
      logic              search_step;
      logic              mac_issue;
      logic [TERM_W-1:0] term;
      logic              check;
      logic              hist_rd_step;
      logic              hist_wr_step;
      logic              hist_rd_bin;
      logic              bin_take;
      logic              clr_step;
      logic              rsp_load;
   } ifs_cmd_type;

   // Status from the datapath
   typedef struct packed {
      op_type op;
      logic   halt;
      logic   search_hit;
      logic   clr_last;
   } ifs_status_type;

endpackage

### rtl/ifs_chaos_game_histogram.sv
// A step runs the divider, then the map search, one weight a cycle, then the shared MAC pipe,
//   the divergence check and the histogram read and increment, and then loads the result.
// Loads and set point act on decode, a bin read after its memory read; a new word follows.
// One word is in flight at a time; the output register holds a result while the next is taken.
// Reset is synchronous: config returns to 1/256/256, point and halt flag clear, then a sweep of
//   all MAX_WIDTH*MAX_HEIGHT bins (65536 by default) zeroes the histogram before any word.
module ifs_chaos_game_histogram #(
   parameter int MAX_MAPS   = ifs_pkg::DEF_MAX_MAPS,
   parameter int MAX_WIDTH  = ifs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ifs_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = ifs_pkg::DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [2:0]         req_map_index,
   input  logic [2:0]         req_coef_index,
   input  logic signed [39:0] req_coef_value,
   input  logic [30:0]        req_cum_weight,
   input  logic signed [39:0] req_start_x,
   input  logic signed [39:0] req_start_y,
   input  logic [30:0]        req_random_word,
   input  logic [7:0]         req_read_col,
   input  logic [7:0]         req_read_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_map_used,
   output logic signed [39:0] rsp_new_x,
   output logic signed [39:0] rsp_new_y,
   output logic               rsp_hit,
   output logic [7:0]         rsp_hit_col,
   output logic [7:0]         rsp_hit_row,
   output logic               rsp_halted,
   output logic [31:0]        rsp_bin_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata
);
   import ifs_pkg::*;

   ifs_cmd_type    cmd;
   ifs_status_type status;

   // Registers are written whenever presented
   assign csr_ready = 1'b1;

   ifs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ifs_dp #(
      .MAX_MAPS   (MAX_MAPS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_map_index   (req_map_index),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .req_cum_weight  (req_cum_weight),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_random_word (req_random_word),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_map_used    (rsp_map_used),
      .rsp_new_x       (rsp_new_x),
      .rsp_new_y       (rsp_new_y),
      .rsp_hit         (rsp_hit),
      .rsp_hit_col     (rsp_hit_col),
      .rsp_hit_row     (rsp_hit_row),
      .rsp_halted      (rsp_halted),
      .rsp_bin_count   (rsp_bin_count)
   );

endmodule

### rtl/ifs_dp.sv
module ifs_dp #(
   parameter int MAX_MAPS   = ifs_pkg::DEF_MAX_MAPS,
   parameter int MAX_WIDTH  = ifs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ifs_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = ifs_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ifs_pkg::ifs_cmd_type          cmd,
   output ifs_pkg::ifs_status_type       status,
   input  logic [2:0]                    req_op,
   input  logic [2:0]                    req_map_index,
   input  logic [2:0]                    req_coef_index,
   input  logic signed [39:0]            req_coef_value,
   input  logic [30:0]                   req_cum_weight,
   input  logic signed [39:0]            req_start_x,
   input  logic signed [39:0]            req_start_y,
   input  logic [30:0]                   req_random_word,
   input  logic [7:0]                    req_read_col,
   input  logic [7:0]                    req_read_row,
   input  logic                          csr_valid,
   input  logic [1:0]                    csr_index,
   input  logic [8:0]                    csr_wdata,
   output logic [2:0]                    rsp_map_used,
   output logic signed [39:0]            rsp_new_x,
   output logic signed [39:0]            rsp_new_y,
   output logic                          rsp_hit,
   output logic [7:0]                    rsp_hit_col,
   output logic [7:0]                    rsp_hit_row,
   output logic                          rsp_halted,
   output logic [31:0]                   rsp_bin_count
);
   import ifs_pkg::*;

   localparam int MAP_W  = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
   localparam int CDEPTH = MAX_MAPS * COEFS_PER_MAP;
   localparam int CA_W   = $clog2(CDEPTH);
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HDEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int HA_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int PROD_W = COORD_W + SPLIT_W + 1;

   localparam longint LIM    = longint'(DIVERGE_LIMIT) << FRAC_BITS;
   localparam longint FIT_HI = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint LIM_HI = (LIM < FIT_HI) ? LIM : FIT_HI;
   localparam longint LIM_LO = (LIM < FIT_HI) ? -LIM : -FIT_HI - 1;
   localparam logic signed [ACC_W-1:0] V_HI      = ACC_W'(LIM_HI);
   localparam logic signed [ACC_W-1:0] V_LO      = ACC_W'(LIM_LO);
   localparam logic signed [ACC_W-1:0] V_NEG_ONE = ACC_W'(-(longint'(1) << FRAC_BITS));

   typedef enum logic [2:0] {CH_XLO, CH_XHI, CH_YLO, CH_YHI, CH_ONE} chunk_type;

   // Term sequence: a*xlo, a*xhi, b*ylo, b*yhi, c, then the same for d, e, f
   function automatic logic [2:0] term_slot(input logic [TERM_W-1:0] t);
      logic [2:0] s;
      case (t)
         4'd0, 4'd1: s = 3'd0;
         4'd2, 4'd3: s = 3'd1;
         4'd4:       s = 3'd2;
         4'd5, 4'd6: s = 3'd3;
         4'd7, 4'd8: s = 3'd4;
         default:    s = 3'd5;
      endcase
      return s;
   endfunction

   function automatic chunk_type term_chunk(input logic [TERM_W-1:0] t);
      chunk_type c;
      case (t)
         4'd0, 4'd5: c = CH_XLO;
         4'd1, 4'd6: c = CH_XHI;
         4'd2, 4'd7: c = CH_YLO;
         4'd3, 4'd8: c = CH_YHI;
         default:    c = CH_ONE;
      endcase
      return c;
   endfunction

   // Captured request word
   op_type               op_ff;
   logic [2:0]           mi_ff, ci_ff;
   logic signed [39:0]   coefv_ff, sx_ff, sy_ff;
   logic [30:0]          cumw_ff, rand_ff;
   logic [7:0]           rcol_ff, rrow_ff;

   // Configuration
   logic [3:0]           map_count_ff;
   logic [8:0]           width_ff, height_ff;

   // Tables and point
   logic signed [39:0]   coef_mem [CDEPTH];
   logic signed [39:0]   coef_rd_ff;
   logic [WEIGHT_W-1:0]  weight_ff [MAX_MAPS];
   logic signed [39:0]   point_x_ff, point_y_ff;
   logic                 halt_ff;

   // Divider and map search
   logic [WEIGHT_W-1:0]  total_ff, dvd_ff, rem_ff, r_ff;
   logic [WEIGHT_W:0]    rem_sh;
   logic [MAP_W-1:0]     j_ff, n_last;
   logic                 search_hit;

   // Multiply-accumulate pipe
   logic                 t1_v_ff, t2_v_ff;
   logic [TERM_W-1:0]    t1_term_ff, t2_term_ff;
   logic signed [20:0]   chunk;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  aligned, acc_x_ff, acc_y_ff;
   logic [CA_W-1:0]      coef_raddr, coef_waddr;
   logic                 coef_ok;

   // Divergence and bin check
   logic signed [ACC_W-1:0] vx, vy, qx, qy;
   logic                 ok_x, ok_y, in_x, in_y;

   // Per-item result
   logic [MAP_W-1:0]     res_map_ff;
   logic                 res_hit_ff;
   logic [COL_W-1:0]     res_col_ff;
   logic [ROW_W-1:0]     res_row_ff;
   logic [BIN_W-1:0]     res_bin_ff;

   // Histogram
   logic [BIN_W-1:0]     hist_mem [HDEPTH];
   logic [BIN_W-1:0]     hist_rd_ff;
   logic [HA_W-1:0]      clr_ff, haddr_step, haddr_bin, hist_raddr;
   logic                 bin_ok;

   // Output word
   logic [2:0]           rsp_map_ff;
   logic signed [39:0]   rsp_x_ff, rsp_y_ff;
   logic                 rsp_hit_ff, rsp_halt_ff;
   logic [7:0]           rsp_col_ff, rsp_row_ff;
   logic [BIN_W-1:0]     rsp_bin_ff;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_op);
         mi_ff    <= req_map_index;
         ci_ff    <= req_coef_index;
         coefv_ff <= req_coef_value;
         cumw_ff  <= req_cum_weight;
         sx_ff    <= req_start_x;
         sy_ff    <= req_start_y;
         rand_ff  <= req_random_word;
         rcol_ff  <= req_read_col;
         rrow_ff  <= req_read_row;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_count_ff <= 4'd1;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_MAP_COUNT:    map_count_ff <= csr_wdata[3:0];
            CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Last map in use
   always_comb begin
      if (map_count_ff == 4'd0)
         n_last = '0;
      else if (int'(map_count_ff) > MAX_MAPS)
         n_last = MAP_W'(MAX_MAPS - 1);
      else
         n_last = MAP_W'(map_count_ff - 4'd1);
   end

   // Coefficient memory
   assign coef_ok    = (int'(mi_ff) < MAX_MAPS) && (int'(ci_ff) < COEFS_PER_MAP);
   assign coef_waddr = CA_W'(mi_ff) * CA_W'(COEFS_PER_MAP) + CA_W'(ci_ff);
   assign coef_raddr = CA_W'(j_ff) * CA_W'(COEFS_PER_MAP) + CA_W'(term_slot(cmd.term));

   always_ff @(posedge clock) begin
      if (cmd.exec_load && op_ff == OP_LOAD_COEF && coef_ok)
         coef_mem[coef_waddr] <= coefv_ff;
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   // Weight table
   always_ff @(posedge clock) begin
      if (cmd.exec_load && op_ff == OP_LOAD_WEIGHT && int'(mi_ff) < MAX_MAPS)
         weight_ff[MAP_W'(mi_ff)] <= cumw_ff;
   end

   // Restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff, dvd_ff[WEIGHT_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         total_ff <= weight_ff[n_last];
         dvd_ff   <= rand_ff;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[WEIGHT_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, total_ff})
            rem_ff <= WEIGHT_W'(rem_sh - {1'b0, total_ff});
         else
            rem_ff <= WEIGHT_W'(rem_sh);
      end
   end

   // Map search, one weight a cycle
   assign search_hit = (j_ff == n_last) || (r_ff <= weight_ff[j_ff]);

   always_ff @(posedge clock) begin
      if (cmd.rem_fin) begin
         r_ff <= (total_ff == '0) ? '0 : rem_ff;
         j_ff <= '0;
      end else if (cmd.search_step && !search_hit) begin
         j_ff <= j_ff + 1'b1;
      end
   end

   // Operand chunk for the coefficient now read; high halves carry the sign
   always_comb begin
      case (term_chunk(t1_term_ff))
         CH_XLO:  chunk = {1'b0, point_x_ff[SPLIT_W-1:0]};
         CH_XHI:  chunk = 21'($signed(point_x_ff[39:SPLIT_W]));
         CH_YLO:  chunk = {1'b0, point_y_ff[SPLIT_W-1:0]};
         CH_YHI:  chunk = 21'($signed(point_y_ff[39:SPLIT_W]));
         default: chunk = 21'sd1;
      endcase
   end

   assign prod_in = coef_rd_ff * chunk;

   always_comb begin
      case (term_chunk(t2_term_ff))
         CH_XHI, CH_YHI: aligned = ACC_W'(prod_ff) <<< SPLIT_W;
         CH_ONE:         aligned = ACC_W'(prod_ff) <<< FRAC_BITS;
         default:        aligned = ACC_W'(prod_ff);
      endcase
   end

   // Pipe: fetch, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
      end else begin
         t1_v_ff <= cmd.mac_issue;
         t2_v_ff <= t1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_term_ff <= cmd.term;
      t2_term_ff <= t1_term_ff;
      prod_ff    <= prod_in;
      if (cmd.rem_fin) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (t2_v_ff) begin
         if (t2_term_ff >= TERM_W'(N_TERMS / 2))
            acc_y_ff <= acc_y_ff + aligned;
         else
            acc_x_ff <= acc_x_ff + aligned;
      end
   end

   // Divergence test and truncated bin position
   assign vx   = acc_x_ff >>> FRAC_BITS;
   assign vy   = acc_y_ff >>> FRAC_BITS;
   assign ok_x = (vx <= V_HI) && (vx >= V_LO);
   assign ok_y = (vy <= V_HI) && (vy >= V_LO);
   assign qx   = vx[ACC_W-1] ? '0 : (vx >>> FRAC_BITS);
   assign qy   = vy[ACC_W-1] ? '0 : (vy >>> FRAC_BITS);
   assign in_x = (!vx[ACC_W-1] || vx > V_NEG_ONE) && (qx < ACC_W'(width_ff))
                 && (qx < ACC_W'(MAX_WIDTH));
   assign in_y = (!vy[ACC_W-1] || vy > V_NEG_ONE) && (qy < ACC_W'(height_ff))
                 && (qy < ACC_W'(MAX_HEIGHT));

   // Point and halt flag
   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
         halt_ff    <= 1'b0;
      end else if (cmd.exec_load && op_ff == OP_SET_POINT) begin
         point_x_ff <= sx_ff;
         point_y_ff <= sy_ff;
         halt_ff    <= 1'b0;
      end else if (cmd.check) begin
         if (!ok_x || !ok_y) begin
            halt_ff <= 1'b1;
         end else begin
            point_x_ff <= vx[39:0];
            point_y_ff <= vy[39:0];
         end
      end
   end

   // Per-item results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_map_ff <= '0;
         res_hit_ff <= 1'b0;
         res_col_ff <= '0;
         res_row_ff <= '0;
         res_bin_ff <= '0;
      end else begin
         if (cmd.search_step && search_hit)
            res_map_ff <= j_ff;
         if (cmd.check && ok_x && ok_y && in_x && in_y) begin
            res_hit_ff <= 1'b1;
            res_col_ff <= qx[COL_W-1:0];
            res_row_ff <= qy[ROW_W-1:0];
         end
         if (cmd.bin_take)
            res_bin_ff <= bin_ok ? hist_rd_ff : '0;
      end
   end

   // Histogram addressing
   assign haddr_step = HA_W'(res_row_ff) * HA_W'(MAX_WIDTH) + HA_W'(res_col_ff);
   assign haddr_bin  = HA_W'(rrow_ff) * HA_W'(MAX_WIDTH) + HA_W'(rcol_ff);
   assign bin_ok     = (int'(rcol_ff) < MAX_WIDTH) && (int'(rrow_ff) < MAX_HEIGHT);
   assign hist_raddr = cmd.hist_rd_bin ? haddr_bin : haddr_step;

   // Clear sweep counter
   always_ff @(posedge clock) begin
      if (reset)
         clr_ff <= '0;
      else if (cmd.clr_step)
         clr_ff <= clr_ff + 1'b1;
   end

   // Histogram memory: clear sweep or saturating increment
   always_ff @(posedge clock) begin
      if (cmd.clr_step)
         hist_mem[clr_ff] <= '0;
      else if (cmd.hist_wr_step && res_hit_ff)
         hist_mem[haddr_step] <= (&hist_rd_ff) ? hist_rd_ff : hist_rd_ff + 1'b1;
      if (cmd.hist_rd_step || cmd.hist_rd_bin)
         hist_rd_ff <= hist_mem[hist_raddr];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_map_ff  <= 3'(res_map_ff);
         rsp_x_ff    <= point_x_ff;
         rsp_y_ff    <= point_y_ff;
         rsp_hit_ff  <= res_hit_ff;
         rsp_col_ff  <= 8'(res_col_ff);
         rsp_row_ff  <= 8'(res_row_ff);
         rsp_halt_ff <= halt_ff;
         rsp_bin_ff  <= res_bin_ff;
      end
   end

   assign rsp_map_used  = rsp_map_ff;
   assign rsp_new_x     = rsp_x_ff;
   assign rsp_new_y     = rsp_y_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_col   = rsp_col_ff;
   assign rsp_hit_row   = rsp_row_ff;
   assign rsp_halted    = rsp_halt_ff;
   assign rsp_bin_count = rsp_bin_ff;

   assign status.op         = op_ff;
   assign status.halt       = halt_ff;
   assign status.search_hit = search_hit;
   assign status.clr_last   = (clr_ff == HA_W'(HDEPTH - 1));

   // A divergence keeps the point
   a_halt_keeps_point: assert property (@(posedge clock) disable iff (reset)
      $rose(halt_ff) |-> ($stable(point_x_ff) && $stable(point_y_ff)))
      else $error("point moved on divergence");

   // Search never runs past the last map in use
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |-> (j_ff <= n_last))
      else $error("map search out of range");

   // Increment follows its read
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      cmd.hist_wr_step |-> $past(cmd.hist_rd_step))
      else $error("bin write without read");

endmodule

### rtl/ifs_ctrl.sv
module ifs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ifs_pkg::ifs_status_type status,
   output ifs_pkg::ifs_cmd_type    cmd
);
   import ifs_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_DIV_INIT, S_DIV, S_RFIN, S_SEARCH,
      S_MAC, S_CHECK, S_HRD, S_HWR, S_BREAD, S_BWAIT, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last)
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               OP_LOAD_COEF, OP_LOAD_WEIGHT, OP_SET_POINT: begin
                  cmd.exec_load = 1'b1;
                  state_in      = S_DONE;
               end
               OP_STEP:     state_in = status.halt ? S_DONE : S_DIV_INIT;
               OP_READ_BIN: state_in = S_BREAD;
               default:     state_in = S_DONE;
            endcase
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_LAST)) begin
               cnt_in   = '0;
               state_in = S_RFIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RFIN: begin
            cmd.rem_fin = 1'b1;
            state_in    = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.search_hit) begin
               cnt_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mac_issue = (cnt_ff < CNT_W'(N_TERMS));
            cmd.term      = TERM_W'(cnt_ff);
            if (cnt_ff == CNT_W'(MAC_LAST))
               state_in = S_CHECK;
            else
               cnt_in = cnt_ff + 1'b1;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_HRD;
         end
         S_HRD: begin
            cmd.hist_rd_step = 1'b1;
            state_in         = S_HWR;
         end
         S_HWR: begin
            cmd.hist_wr_step = 1'b1;
            state_in         = S_DONE;
         end
         S_BREAD: begin
            cmd.hist_rd_bin = 1'b1;
            state_in        = S_BWAIT;
         end
         S_BWAIT: begin
            cmd.bin_take = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted word is decoded next
   a_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted word not decoded");

   // The clear sweep runs once after reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |=> (state_ff != S_CLEAR))
      else $error("clear sweep restarted");

   // A finished item shows up on the output
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("result word lost");

endmodule

### test/tb.sv
module tb;
   import ifs_pkg::*;

   localparam int FRAC = 16;
   localparam int WATCH_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 80;

   // one request word
   typedef struct {
      logic [2:0]         op;
      logic [2:0]         map_index;
      logic [2:0]         coef_index;
      logic signed [39:0] coef_value;
      logic [30:0]        cum_weight;
      logic signed [39:0] start_x;
      logic signed [39:0] start_y;
      logic [30:0]        random_word;
      logic [7:0]         read_col;
      logic [7:0]         read_row;
   } ifs_word_type;

   // one response word
   typedef struct {
      logic [2:0]         map_used;
      logic signed [39:0] new_x;
      logic signed [39:0] new_y;
      logic               hit;
      logic [7:0]         hit_col;
      logic [7:0]         hit_row;
      logic               halted;
      logic [31:0]        bin_count;
   } ifs_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_op = 0;
   logic [2:0] req_map_index = 0;
   logic [2:0] req_coef_index = 0;
   logic signed [39:0] req_coef_value = 0;
   logic [30:0] req_cum_weight = 0;
   logic signed [39:0] req_start_x = 0;
   logic signed [39:0] req_start_y = 0;
   logic [30:0] req_random_word = 0;
   logic [7:0] req_read_col = 0;
   logic [7:0] req_read_row = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_map_used;
   logic signed [39:0] rsp_new_x;
   logic signed [39:0] rsp_new_y;
   logic rsp_hit;
   logic [7:0] rsp_hit_col;
   logic [7:0] rsp_hit_row;
   logic rsp_halted;
   logic [31:0] rsp_bin_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_MAP_COUNT;
   logic [8:0] csr_wdata = 0;

   ifs_chaos_game_histogram dut (.*);

   always #1 clock = ~clock;

   // shadow copy of the renderer
   logic signed [39:0] shadow_coef [48];
   logic [30:0]        shadow_weight [8];
   logic signed [39:0] shadow_x, shadow_y;
   logic               shadow_halt;
   int unsigned        shadow_hist [int];
   logic [3:0]         shadow_maps;
   logic [8:0]         shadow_width, shadow_height;

   ifs_word_type words_to_send [$];
   ifs_rsp_type  expected_rsps [$];
   int        visited_bins [$];
   int        words_queued = 0, words_taken = 0, csr_taken = 0, errors = 0;
   logic      req_fired = 0;
   bit        calm = 0;

   task automatic report(string what, longint got, longint want);
      $display("%s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   // one coordinate of the affine map; ok is low when the orbit diverges
   task automatic affine_coord(input logic signed [39:0] a, b, c, x, y,
                               output logic ok, output logic signed [39:0] v);
      logic signed [127:0] ea, eb, ec, ex, ey, s, lim;
      ea = a; eb = b; ec = c; ex = x; ey = y;
      lim = 128'sd100000 <<< FRAC;
      s = ea * ex + eb * ey + (ec <<< FRAC);
      s = s >>> FRAC;
      ok = (s <= lim) && (s >= -lim);
      v = s[39:0];
   endtask

   // truncate toward zero and test against the image bound
   function automatic bit bin_pos(logic signed [39:0] v, int bound, output int pos);
      longint vv, q;
      vv = v;
      q = (vv < 0 ? -vv : vv) >>> FRAC;
      pos = int'(q);
      if (vv < 0 && q != 0) return 0;
      return q < bound;
   endfunction

   task automatic render_word(input ifs_word_type w, output ifs_rsp_type r);
      int n, j, col, row, wd, ht, addr;
      logic [30:0] total, rem;
      logic okx, oky;
      logic signed [39:0] nx, ny;
      r = '{default: 0};
      case (w.op)
         OP_LOAD_COEF: if (w.coef_index < 6) shadow_coef[w.map_index*6 + w.coef_index] = w.coef_value;
         OP_LOAD_WEIGHT: shadow_weight[w.map_index] = w.cum_weight;
         OP_SET_POINT: begin
            shadow_x = w.start_x;
            shadow_y = w.start_y;
            shadow_halt = 0;
         end
         OP_STEP: if (!shadow_halt) begin
            n = shadow_maps == 0 ? 1 : (shadow_maps > 8 ? 8 : shadow_maps);
            total = shadow_weight[n-1];
            rem = total == 0 ? 0 : w.random_word % total;
            for (j = 0; j < n - 1; j++)
               if (rem <= shadow_weight[j]) break;
            r.map_used = j;
            affine_coord(shadow_coef[j*6], shadow_coef[j*6+1], shadow_coef[j*6+2],
                         shadow_x, shadow_y, okx, nx);
            affine_coord(shadow_coef[j*6+3], shadow_coef[j*6+4], shadow_coef[j*6+5],
                         shadow_x, shadow_y, oky, ny);
            if (!okx || !oky) shadow_halt = 1;
            else begin
               shadow_x = nx;
               shadow_y = ny;
               wd = shadow_width > 256 ? 256 : shadow_width;
               ht = shadow_height > 256 ? 256 : shadow_height;
               if (bin_pos(nx, wd, col) && bin_pos(ny, ht, row)) begin
                  addr = row * 256 + col;
                  if (!shadow_hist.exists(addr)) shadow_hist[addr] = 0;
                  if (shadow_hist[addr] != 32'hFFFF_FFFF) shadow_hist[addr]++;
                  visited_bins.push_back(addr);
                  r.hit = 1;
                  r.hit_col = col;
                  r.hit_row = row;
               end
            end
         end
         OP_READ_BIN: begin
            addr = w.read_row * 256 + w.read_col;
            r.bin_count = shadow_hist.exists(addr) ? shadow_hist[addr] : 0;
         end
         default: ;
      endcase
      r.new_x = shadow_x;
      r.new_y = shadow_y;
      r.halted = shadow_halt;
   endtask

   // monitor: check responses, track config writes, predict accepted words
   always @(posedge clock) begin
      ifs_rsp_type want, got;
      req_fired <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_map_used, rsp_new_x, rsp_new_y, rsp_hit, rsp_hit_col,
                    rsp_hit_row, rsp_halted, rsp_bin_count};
            if (expected_rsps.size() == 0) report("unexpected word", 0, 0);
            else begin
               want = expected_rsps.pop_front();
               if (got.map_used !== want.map_used) report("map_used", got.map_used, want.map_used);
               if (got.new_x !== want.new_x) report("new_x", got.new_x, want.new_x);
               if (got.new_y !== want.new_y) report("new_y", got.new_y, want.new_y);
               if (got.hit !== want.hit) report("hit", got.hit, want.hit);
               if (got.hit_col !== want.hit_col) report("hit_col", got.hit_col, want.hit_col);
               if (got.hit_row !== want.hit_row) report("hit_row", got.hit_row, want.hit_row);
               if (got.halted !== want.halted) report("halted", got.halted, want.halted);
               if (got.bin_count !== want.bin_count)
                  report("bin_count", got.bin_count, want.bin_count);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAP_COUNT:    shadow_maps = csr_wdata[3:0];
               CSR_IMAGE_WIDTH:  shadow_width = csr_wdata;
               CSR_IMAGE_HEIGHT: shadow_height = csr_wdata;
               default: ;
            endcase
            csr_taken <= csr_taken + 1;
         end
         if (req_valid && req_ready) begin
            render_word('{req_op, req_map_index, req_coef_index, req_coef_value,
                          req_cum_weight, req_start_x, req_start_y, req_random_word,
                          req_read_col, req_read_row}, want);
            expected_rsps.push_back(want);
            words_taken <= words_taken + 1;
         end
      end
   end

   // request driver with random idle bursts
   int send_gap = 0;
   always @(negedge clock) begin
      ifs_word_type w;
      if (!reset && (!req_valid || req_fired)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 7);
            req_valid <= 0;
         end else if (words_to_send.size() > 0) begin
            w = words_to_send.pop_front();
            req_op <= w.op;
            req_map_index <= w.map_index;
            req_coef_index <= w.coef_index;
            req_coef_value <= w.coef_value;
            req_cum_weight <= w.cum_weight;
            req_start_x <= w.start_x;
            req_start_y <= w.start_y;
            req_random_word <= w.random_word;
            req_read_col <= w.read_col;
            req_read_row <= w.read_row;
            req_valid <= 1;
         end else req_valid <= 0;
      end
   end

   // response stalls in bursts
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready <= 0;
      end else rsp_ready <= 1;
   end

   // watchdog on cycles with no handshake
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCH_LIMIT) begin
         $display("ifs_chaos_game_histogram: mismatch");
         $finish;
      end
   end

   function automatic ifs_word_type noisy_word();
      ifs_word_type w;
      w.op = $urandom;
      w.map_index = $urandom;
      w.coef_index = $urandom;
      w.coef_value = {$urandom, $urandom};
      w.cum_weight = $urandom;
      w.start_x = {$urandom, $urandom};
      w.start_y = {$urandom, $urandom};
      w.random_word = $urandom;
      w.read_col = $urandom;
      w.read_row = $urandom;
      return w;
   endfunction

   // contractive linear terms, offsets spread over the image
   function automatic logic signed [39:0] tame_coef(int slot);
      int v;
      if (slot == 2 || slot == 5) v = $urandom_range(0, 280 << FRAC) - (20 << FRAC);
      else v = $urandom_range(0, 65536) - 32768;
      return v;
   endfunction

   task automatic queue_coef(int m, int slot, logic signed [39:0] v);
      ifs_word_type w;
      w = noisy_word();
      w.op = OP_LOAD_COEF; w.map_index = m; w.coef_index = slot; w.coef_value = v;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic queue_weight(int m, logic [30:0] v);
      ifs_word_type w;
      w = noisy_word();
      w.op = OP_LOAD_WEIGHT; w.map_index = m; w.cum_weight = v;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic queue_point(logic signed [39:0] x, logic signed [39:0] y);
      ifs_word_type w;
      w = noisy_word();
      w.op = OP_SET_POINT; w.start_x = x; w.start_y = y;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic queue_step(logic [30:0] rnd);
      ifs_word_type w;
      w = noisy_word();
      w.op = OP_STEP; w.random_word = rnd;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic queue_read(int col, int row);
      ifs_word_type w;
      w = noisy_word();
      w.op = OP_READ_BIN; w.read_col = col; w.read_row = row;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   task automatic queue_other(logic [2:0] code);
      ifs_word_type w;
      w = noisy_word();
      w.op = code;
      words_to_send.push_back(w);
      words_queued++;
   endtask

   // config writes keep valid high across the three registers
   task automatic write_regs(int maps, int wd, int ht);
      int vals [3];
      vals = '{maps, wd, ht};
      for (int i = 0; i < 3; i++) begin
         int target;
         target = csr_taken + 1;
         csr_index <= csr_type'(i);
         csr_wdata <= vals[i];
         csr_valid <= 1;
         @(negedge clock);
         while (csr_taken != target) @(negedge clock);
      end
      csr_valid <= 0;
   endtask

   // hold off until every expected word is back, then let the block settle
   task automatic drain();
      while (words_taken != words_queued || expected_rsps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(int count);
      int k, slot, m, pick;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) queue_step($urandom);
         else if (pick < 65) begin
            if (visited_bins.size() > 0 && $urandom_range(0, 1)) begin
               m = visited_bins[$urandom_range(0, visited_bins.size() - 1)];
               queue_read(m % 256, m / 256);
            end else queue_read($urandom_range(0, 255), $urandom_range(0, 255));
         end else if (pick < 73) begin
            if ($urandom_range(0, 7) == 0) queue_point({$urandom, $urandom}, {$urandom, $urandom});
            else queue_point(($urandom_range(0, 300) - 20) <<< FRAC,
                             ($urandom_range(0, 300) - 20) <<< FRAC);
         end else if (pick < 83) begin
            slot = $urandom_range(0, 9) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5);
            queue_coef($urandom_range(0, 7), slot, tame_coef(slot));
         end else if (pick < 90) begin
            queue_weight($urandom_range(0, 7),
                         $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000));
         end else if (pick < 95) begin
            // wild coefficient, a step on it, then recovery
            m = $urandom_range(0, 7);
            slot = $urandom_range(0, 5);
            queue_coef(m, slot, {$urandom, $urandom});
            queue_step($urandom);
            queue_point(5 <<< FRAC, 7 <<< FRAC);
            queue_coef(m, slot, tame_coef(slot));
         end else queue_other($urandom_range(5, 7));
      end
   endtask

   initial begin
      int phase_maps [6];
      int phase_w [6];
      int phase_h [6];
      // widths, heights and map counts per phase, extremes among them
      phase_maps = '{8, 3, 0, 15, 8, 5};
      phase_w    = '{256, 100, 1, 511, 0, 200};
      phase_h    = '{256, 60, 1, 511, 256, 256};
      foreach (shadow_coef[i]) shadow_coef[i] = 0;
      foreach (shadow_weight[i]) shadow_weight[i] = 0;
      shadow_x = 0; shadow_y = 0; shadow_halt = 0;
      shadow_maps = 1; shadow_width = 256; shadow_height = 256;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // fill both tables before any step
      for (int m = 0; m < 8; m++) begin
         for (int s = 0; s < 6; s++) queue_coef(m, s, tame_coef(s));
         queue_weight(m, (m + 1) * 100 + $urandom_range(0, 99));
      end

      // directed cases, single map in use
      queue_weight(0, 0);
      queue_step(31'h7FFF_FFFF);              // zero total weight
      queue_coef(0, 6, 40'sh7F_FFFF_FFFF);    // bad slots are ignored
      queue_coef(0, 7, 40'sh80_0000_0000);
      queue_coef(0, 0, 65536); queue_coef(0, 1, 0); queue_coef(0, 2, 0);
      queue_coef(0, 3, 0); queue_coef(0, 4, 65536); queue_coef(0, 5, 0);
      queue_point(-32768, 5 <<< FRAC);
      queue_step(0);                          // minus half truncates to column 0
      queue_point(300 <<< FRAC, 3 <<< FRAC);
      queue_step(0);                          // outside the image
      queue_point(40'sh7F_FFFF_FFFF, 40'sh80_0000_0000);
      queue_step(0);                          // diverges
      queue_step(0);                          // ignored while halted
      queue_coef(0, 0, 40'sh80_0000_0000);
      queue_point(1 <<< FRAC, 0);
      queue_step(0);
      queue_coef(0, 0, 65536);
      queue_weight(0, 31'h7FFF_FFFF);
      queue_point(0, 0);
      queue_step(31'h7FFF_FFFF);
      queue_read(0, 0);
      queue_read(0, 5);
      queue_read(255, 255);
      queue_other(5); queue_other(6); queue_other(7);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_regs(phase_maps[p], phase_w[p], phase_h[p]);
         if (p == 5) calm = 1;
         random_phase(60);
         drain();
      end

      if (errors == 0) $display("ifs_chaos_game_histogram: match");
      else $display("ifs_chaos_game_histogram: mismatch");
      $finish;
   end

endmodule
